/* rtl/esc_pkg.sv */
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types and constants of the escape byte stuffing codec.
// ----------------------------------------------------------------------------
package esc_pkg;

  // Escape character and the codes that follow it
  localparam logic [7:0] ESC_CHAR = 8'h1B;
  localparam logic [7:0] CODE_LF  = 8'h01;
  localparam logic [7:0] CODE_CR  = 8'h02;
  localparam logic [7:0] CODE_ESC = 8'h03;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;

  // Result kinds
  localparam logic [1:0] KIND_BYTE      = 2'd0;
  localparam logic [1:0] KIND_END       = 2'd1;
  localparam logic [1:0] KIND_TRAIL_ESC = 2'd2;
  localparam logic [1:0] KIND_BAD_ESC   = 2'd3;

  // Modes
  localparam logic MODE_DECODE = 1'b0;
  localparam logic MODE_ENCODE = 1'b1;

  // Register byte addresses
  localparam logic [2:0] REG_START_ADDR = 3'h0;
  localparam logic [2:0] REG_STOP_ADDR  = 3'h4;

  // Register reset values
  localparam logic [7:0] START_RESET = 8'h02;
  localparam logic [7:0] STOP_RESET  = 8'h04;

  // Most results one item can cause
  localparam int MAX_RES = 4;

  // One result item
  typedef struct packed {
    logic [7:0] value;
    logic [1:0] kind;
    logic       eor;
  } res_t;

  // Result list handed from the core to the serialiser
  typedef struct packed {
    logic                  valid;
    logic [2:0]            cnt;
    res_t [MAX_RES-1:0]    ent;
  } load_t;

endpackage

/* rtl/esc_cfg.sv */
// ----------------------------------------------------------------------------
// esc_cfg
// Configuration register file: start and stop delimiter bytes.
// ----------------------------------------------------------------------------
module esc_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  start_byte,
  output logic [7:0]  stop_byte
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= esc_pkg::START_RESET;
      stop_byte  <= esc_pkg::STOP_RESET;
    end else if (wr_en) begin
      if (paddr == esc_pkg::REG_START_ADDR) begin
        start_byte <= pwdata[7:0];
      end else if (paddr == esc_pkg::REG_STOP_ADDR) begin
        stop_byte <= pwdata[7:0];
      end
    end
  end

  // Read back the addressed register, zero elsewhere
  always_comb begin
    prdata = '0;
    if (paddr == esc_pkg::REG_START_ADDR) begin
      prdata[7:0] = start_byte;
    end else if (paddr == esc_pkg::REG_STOP_ADDR) begin
      prdata[7:0] = stop_byte;
    end
  end

endmodule

/* rtl/esc_core.sv */
// ----------------------------------------------------------------------------
// esc_core
// Input register, decoder state and the single-pass encode/decode logic
// that turns one item into a list of up to four results.
// ----------------------------------------------------------------------------
module esc_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,
  input  logic [1:0]    s_tuser,
  input  logic          s_tlast,
  input  logic [7:0]    start_byte,
  input  logic [7:0]    stop_byte,
  input  logic          list_free,
  output esc_pkg::load_t load
);

  // Input register
  logic       in_valid;
  logic       in_mode;
  logic [7:0] in_data;
  logic       in_first;
  logic       in_last;
  logic       in_move;

  // Decoder state
  logic escape_pending;
  logic discarding;
  logic escape_pending_next;
  logic discarding_next;

  logic [2:0]                         cnt_next;
  esc_pkg::res_t [esc_pkg::MAX_RES-1:0] ent_next;

  assign in_move  = in_valid && list_free;
  assign s_tready = !in_valid || in_move;

  // Hold or advance the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode  <= s_tuser[0];
      in_first <= s_tuser[1];
      in_data  <= s_tdata;
      in_last  <= s_tlast;
    end
  end

  // Build the result list and the next decoder state
  always_comb begin
    logic done;
    done                = 1'b0;
    cnt_next            = 3'd0;
    ent_next            = '0;
    escape_pending_next = escape_pending;
    discarding_next     = discarding;

    if (in_mode == esc_pkg::MODE_ENCODE) begin
      escape_pending_next = 1'b0;
      discarding_next     = 1'b0;
      if (in_first) begin
        ent_next[cnt_next[1:0]] = '{start_byte, esc_pkg::KIND_BYTE, 1'b0};
        cnt_next = cnt_next + 3'd1;
      end
      if (in_data == esc_pkg::CHAR_LF || in_data == esc_pkg::CHAR_CR ||
          in_data == esc_pkg::ESC_CHAR) begin
        ent_next[cnt_next[1:0]] = '{esc_pkg::ESC_CHAR, esc_pkg::KIND_BYTE, 1'b0};
        cnt_next = cnt_next + 3'd1;
        if (in_data == esc_pkg::CHAR_LF) begin
          ent_next[cnt_next[1:0]] = '{esc_pkg::CODE_LF, esc_pkg::KIND_BYTE, 1'b0};
        end else if (in_data == esc_pkg::CHAR_CR) begin
          ent_next[cnt_next[1:0]] = '{esc_pkg::CODE_CR, esc_pkg::KIND_BYTE, 1'b0};
        end else begin
          ent_next[cnt_next[1:0]] = '{esc_pkg::CODE_ESC, esc_pkg::KIND_BYTE, 1'b0};
        end
        cnt_next = cnt_next + 3'd1;
      end else begin
        ent_next[cnt_next[1:0]] = '{in_data, esc_pkg::KIND_BYTE, 1'b0};
        cnt_next = cnt_next + 3'd1;
      end
      if (in_last) begin
        ent_next[cnt_next[1:0]] = '{stop_byte, esc_pkg::KIND_BYTE, 1'b1};
        cnt_next = cnt_next + 3'd1;
      end
    end else begin
      // A first byte abandons any unfinished message
      if (in_first) begin
        escape_pending_next = 1'b0;
        discarding_next     = 1'b0;
      end
      if (!discarding_next) begin
        if (escape_pending_next) begin
          escape_pending_next = 1'b0;
          if (in_data == esc_pkg::CODE_LF) begin
            ent_next[0] = '{esc_pkg::CHAR_LF, esc_pkg::KIND_BYTE, 1'b0};
            cnt_next    = 3'd1;
          end else if (in_data == esc_pkg::CODE_CR) begin
            ent_next[0] = '{esc_pkg::CHAR_CR, esc_pkg::KIND_BYTE, 1'b0};
            cnt_next    = 3'd1;
          end else if (in_data == esc_pkg::CODE_ESC) begin
            ent_next[0] = '{esc_pkg::ESC_CHAR, esc_pkg::KIND_BYTE, 1'b0};
            cnt_next    = 3'd1;
          end else begin
            ent_next[0]     = '{8'd0, esc_pkg::KIND_BAD_ESC, 1'b1};
            cnt_next        = 3'd1;
            discarding_next = 1'b1;
            done            = 1'b1;
          end
        end else if (in_data == stop_byte) begin
          ent_next[0]     = '{8'd0, esc_pkg::KIND_END, 1'b1};
          cnt_next        = 3'd1;
          discarding_next = 1'b1;
          done            = 1'b1;
        end else if (in_data == esc_pkg::ESC_CHAR) begin
          done = 1'b1;
          if (in_last) begin
            ent_next[0]     = '{8'd0, esc_pkg::KIND_TRAIL_ESC, 1'b1};
            cnt_next        = 3'd1;
            discarding_next = 1'b1;
          end else begin
            escape_pending_next = 1'b1;
          end
        end else begin
          ent_next[0] = '{in_data, esc_pkg::KIND_BYTE, 1'b0};
          cnt_next    = 3'd1;
        end
        // Close the message on its last byte
        if (!done && in_last) begin
          ent_next[cnt_next[1:0]] = '{8'd0, esc_pkg::KIND_END, 1'b1};
          cnt_next        = cnt_next + 3'd1;
          discarding_next = 1'b1;
        end
      end
    end
  end

  // Advance decoder state as the item moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      discarding     <= 1'b0;
    end else if (in_move) begin
      escape_pending <= escape_pending_next;
      discarding     <= discarding_next;
    end
  end

  assign load.valid = in_move && (cnt_next != 3'd0);
  assign load.cnt   = cnt_next;
  assign load.ent   = ent_next;

  // A pending escape and discarding never hold together
  a_state_excl: assert property (@(posedge clk) disable iff (rst)
    !(escape_pending && discarding))
    else $error("escape pending while discarding");

  // An encode item always yields at least one result
  a_enc_res: assert property (@(posedge clk) disable iff (rst)
    (in_move && in_mode == esc_pkg::MODE_ENCODE) |-> load.valid)
    else $error("encode item without result");

  // An item only moves into a free result list
  a_move_free: assert property (@(posedge clk) disable iff (rst)
    load.valid |-> list_free)
    else $error("result list overwritten");

endmodule

/* rtl/esc_ser.sv */
// ----------------------------------------------------------------------------
// esc_ser
// Result register: holds the list of one item and sends its entries one per
// cycle on the output stream while the output is ready.
// ----------------------------------------------------------------------------
module esc_ser (
  input  logic           clk,
  input  logic           rst,
  input  esc_pkg::load_t load,
  output logic           list_free,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [7:0]     m_tdata,
  output logic [1:0]     m_tuser,
  output logic           m_tlast
);

  logic                                 list_valid;
  logic [2:0]                           cnt;
  logic [1:0]                           idx;
  esc_pkg::res_t [esc_pkg::MAX_RES-1:0] ent;
  logic                                 take;
  logic                                 last_ent;

  assign take      = m_tvalid && m_tready;
  assign last_ent  = ({1'b0, idx} == cnt - 3'd1);
  assign list_free = !list_valid || (take && last_ent);

  // Load a new list, step through it, drop it when done
  always_ff @(posedge clk) begin
    if (rst) begin
      list_valid <= 1'b0;
      idx        <= 2'd0;
    end else if (load.valid) begin
      list_valid <= 1'b1;
      idx        <= 2'd0;
    end else if (take && last_ent) begin
      list_valid <= 1'b0;
    end else if (take) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load.valid) begin
      cnt <= load.cnt;
      ent <= load.ent;
    end
  end

  assign m_tvalid = list_valid;
  assign m_tdata  = ent[idx].value;
  assign m_tuser  = ent[idx].kind;
  assign m_tlast  = ent[idx].eor;

  // A loaded list is offered in the next cycle
  a_load_shown: assert property (@(posedge clk) disable iff (rst)
    load.valid |=> m_tvalid)
    else $error("loaded list not offered");

  // Count and index stay within the list
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (cnt != 3'd0 && cnt <= 3'd4 && {1'b0, idx} < cnt))
    else $error("result index out of range");

  // Taking the final entry with nothing new empties the list
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (take && last_ent && !load.valid) |=> !m_tvalid)
    else $error("list not released");

endmodule

/* rtl/escape_byte_stuffing_codec_unit.sv */
// ----------------------------------------------------------------------------
// escape_byte_stuffing_codec_unit
// Escape byte stuffing codec: frames and escapes bytes, or undoes it.
// ----------------------------------------------------------------------------
// An item passes an input register and the encode/decode logic and lands in a
// result register, from which its results are offered on the output stream.
// Each item causes zero to four results, which leave one per cycle while the
// output is ready; the output side therefore sets the rate, and items with at
// most one result flow at one per cycle when the output does not stall. The
// input register takes a new item whenever it is empty or its item moves on,
// which happens when the result register is empty or the final result of the
// item ahead is taken.
// Input tuser carries mode (bit 0, 1 encodes) and first (bit 1); output tuser
// carries the result kind. Registers: start byte at 0x0, stop byte at 0x4.
module escape_byte_stuffing_codec_unit (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_tuser,   // [0] mode, [1] first
  input  logic        s_tlast,
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]     start_byte;
  logic [7:0]     stop_byte;
  logic           list_free;
  esc_pkg::load_t load;

  esc_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .start_byte (start_byte),
    .stop_byte  (stop_byte)
  );

  esc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .start_byte (start_byte),
    .stop_byte  (stop_byte),
    .list_free  (list_free),
    .load       (load)
  );

  esc_ser u_ser (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .list_free (list_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

/* tb/escape_byte_stuffing_codec_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_byte_stuffing_codec_unit_tb
// Self-checking bench for the escape byte stuffing codec. Items go in on the
// input stream in encode and decode mode. A predictor that tracks the decoder
// state and the delimiter registers builds the expected result items. Each
// result taken from the output stream is compared with the oldest expected
// one. Directed messages cover the escape codes, delimiters and error paths.
// Random framed messages and noise then run under several idling patterns and
// several delimiter settings.
// ----------------------------------------------------------------------------
module escape_byte_stuffing_codec_unit_tb;

  // Cycles a result may still be in flight once the expected list is empty
  localparam int DRAIN_CYCLES = 8;
  // Random items sent in each idling phase
  localparam int PHASE_ITEMS = 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;  // [7:0] data_byte
  logic [1:0]  s_tuser = '0;  // [0] mode, [1] first
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;       // [7:0] out_byte
  logic [1:0]  m_tuser;       // [1:0] kind
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state: delimiter registers and decoder state
  logic [7:0] cfg_start = esc_pkg::START_RESET;
  logic [7:0] cfg_stop  = esc_pkg::STOP_RESET;
  logic       dec_escape_pending = 1'b0;
  logic       dec_dropping = 1'b0;

  esc_pkg::res_t expected_results[$];
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   items_sent = 0;
  int   results_checked = 0;
  int   error_count = 0;

  escape_byte_stuffing_codec_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stall the output side at the rate of the current phase
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare every result item taken with the oldest expectation
  always @(posedge clk) begin : check_results
    esc_pkg::res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: actual byte %02h kind %0d end %0b",
                 $time, m_tdata, m_tuser, m_tlast);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (m_tdata !== want.value || m_tuser !== want.kind ||
            m_tlast !== want.eor) begin
          $display({"%0t: mismatch: expected byte %02h kind %0d end %0b, ",
                    "actual byte %02h kind %0d end %0b"},
                   $time, want.value, want.kind, want.eor, m_tdata, m_tuser, m_tlast);
          error_count++;
        end
      end
    end
  end

  function automatic void push_result(input logic [7:0] value, input logic [1:0] kind,
                                      input logic eor);
    esc_pkg::res_t r;
    r.value = value;
    r.kind  = kind;
    r.eor   = eor;
    expected_results.insert(expected_results.size(), r);
  endfunction

  // Work out the result items of one accepted item and advance the state
  function automatic void predict_codec(input logic mode, input logic [7:0] b,
                                        input logic first, input logic last);
    if (mode == esc_pkg::MODE_ENCODE) begin
      // Encoding abandons any message the decoder was in
      dec_escape_pending = 1'b0;
      dec_dropping = 1'b0;
      if (first) push_result(cfg_start, esc_pkg::KIND_BYTE, 1'b0);
      case (b)
        esc_pkg::CHAR_LF: begin
          push_result(esc_pkg::ESC_CHAR, esc_pkg::KIND_BYTE, 1'b0);
          push_result(esc_pkg::CODE_LF, esc_pkg::KIND_BYTE, 1'b0);
        end
        esc_pkg::CHAR_CR: begin
          push_result(esc_pkg::ESC_CHAR, esc_pkg::KIND_BYTE, 1'b0);
          push_result(esc_pkg::CODE_CR, esc_pkg::KIND_BYTE, 1'b0);
        end
        esc_pkg::ESC_CHAR: begin
          push_result(esc_pkg::ESC_CHAR, esc_pkg::KIND_BYTE, 1'b0);
          push_result(esc_pkg::CODE_ESC, esc_pkg::KIND_BYTE, 1'b0);
        end
        default: push_result(b, esc_pkg::KIND_BYTE, 1'b0);
      endcase
      if (last) push_result(cfg_stop, esc_pkg::KIND_BYTE, 1'b1);
      return;
    end

    if (first) begin
      dec_escape_pending = 1'b0;
      dec_dropping = 1'b0;
    end
    if (dec_dropping) return;

    if (dec_escape_pending) begin
      // The byte after an escape is always a code, even the stop value
      dec_escape_pending = 1'b0;
      case (b)
        esc_pkg::CODE_LF:  push_result(esc_pkg::CHAR_LF, esc_pkg::KIND_BYTE, 1'b0);
        esc_pkg::CODE_CR:  push_result(esc_pkg::CHAR_CR, esc_pkg::KIND_BYTE, 1'b0);
        esc_pkg::CODE_ESC: push_result(esc_pkg::ESC_CHAR, esc_pkg::KIND_BYTE, 1'b0);
        default: begin
          push_result(8'h00, esc_pkg::KIND_BAD_ESC, 1'b1);
          dec_dropping = 1'b1;
          return;
        end
      endcase
    end else if (b == cfg_stop) begin
      // Stop test comes before the escape test
      push_result(8'h00, esc_pkg::KIND_END, 1'b1);
      dec_dropping = 1'b1;
      return;
    end else if (b == esc_pkg::ESC_CHAR) begin
      if (last) begin
        push_result(8'h00, esc_pkg::KIND_TRAIL_ESC, 1'b1);
        dec_dropping = 1'b1;
      end else begin
        dec_escape_pending = 1'b1;
      end
      return;
    end else begin
      push_result(b, esc_pkg::KIND_BYTE, 1'b0);
    end

    if (last) begin
      push_result(8'h00, esc_pkg::KIND_END, 1'b1);
      dec_dropping = 1'b1;
    end
  endfunction

  // Send one item, idling first at the phase rate; valid stays high afterwards
  task automatic send_item(input logic mode, input logic [7:0] b, input logic first,
                           input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= {first, mode};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    predict_codec(mode, b, first, last);
    items_sent++;
  endtask

  // Drop valid and wait until every expected result has come, then a little more
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write one register, then read it back
  task automatic config_reg(input logic [2:0] addr, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (addr == esc_pkg::REG_START_ADDR) cfg_start = value;
    else cfg_stop = value;
    // Read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[7:0] !== value) begin
      $display("%0t: mismatch: register %0h expected %02h, actual %02h",
               $time, addr, value, prdata[7:0]);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_delimiters(input logic [7:0] start_val, input logic [7:0] stop_val);
    wait_idle();
    config_reg(esc_pkg::REG_START_ADDR, start_val);
    config_reg(esc_pkg::REG_STOP_ADDR, stop_val);
  endtask

  // Biased byte: escape-related values and delimiters turn up often
  function automatic logic [7:0] pick_byte();
    logic [7:0] specials[10];
    specials = '{esc_pkg::CHAR_LF, esc_pkg::CHAR_CR, esc_pkg::ESC_CHAR,
                 esc_pkg::CODE_LF, esc_pkg::CODE_CR, esc_pkg::CODE_ESC,
                 cfg_stop, cfg_start, 8'h00, 8'hFF};
    if ($urandom_range(99) < 40) return specials[$urandom_range(9)];
    return 8'($urandom_range(255));
  endfunction

  // Plain decode byte: neither escape nor the stop value
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == esc_pkg::ESC_CHAR || b == cfg_stop);
    return b;
  endfunction

  // Encode: escape codes, delimiters, extremes of the byte
  task automatic test_encode_directed();
    send_item(esc_pkg::MODE_ENCODE, esc_pkg::CHAR_LF, 1'b1, 1'b1);
    send_item(esc_pkg::MODE_ENCODE, esc_pkg::CHAR_CR, 1'b1, 1'b0);
    send_item(esc_pkg::MODE_ENCODE, esc_pkg::ESC_CHAR, 1'b0, 1'b0);
    send_item(esc_pkg::MODE_ENCODE, 8'h00, 1'b0, 1'b0);
    send_item(esc_pkg::MODE_ENCODE, 8'hFF, 1'b0, 1'b0);
    send_item(esc_pkg::MODE_ENCODE, cfg_stop, 1'b0, 1'b1);
  endtask

  // Decode: escape pairs, stop, errors, abandoned messages
  task automatic test_decode_directed();
    // Every escape code, then an escaped stop value taken as a bad code
    send_item(esc_pkg::MODE_DECODE, 8'h41, 1'b1, 1'b0);
    send_item(esc_pkg::MODE_DECODE, esc_pkg::ESC_CHAR, 1'b0, 1'b0);
    send_item(esc_pkg::MODE_DECODE, esc_pkg::CODE_LF, 1'b0, 1'b0);
    send_item(esc_pkg::MODE_DECODE, esc_pkg::ESC_CHAR, 1'b0, 1'b0);
    send_item(esc_pkg::MODE_DECODE, esc_pkg::CODE_CR, 1'b0, 1'b0);
    send_item(esc_pkg::MODE_DECODE, esc_pkg::ESC_CHAR, 1'b0, 1'b0);
    send_item(esc_pkg::MODE_DECODE, esc_pkg::CODE_ESC, 1'b0, 1'b0);
    send_item(esc_pkg::MODE_DECODE, esc_pkg::ESC_CHAR, 1'b0, 1'b0);
    send_item(esc_pkg::MODE_DECODE, cfg_stop, 1'b0, 1'b0);
    // Dropped, last byte too
    send_item(esc_pkg::MODE_DECODE, 8'h34, 1'b0, 1'b1);
    // Unescaped stop byte
    send_item(esc_pkg::MODE_DECODE, 8'h55, 1'b1, 1'b0);
    send_item(esc_pkg::MODE_DECODE, cfg_stop, 1'b0, 1'b0);
    // Escape as the last byte
    send_item(esc_pkg::MODE_DECODE, esc_pkg::ESC_CHAR, 1'b1, 1'b1);
    // Message closed by its last byte
    send_item(esc_pkg::MODE_DECODE, 8'h10, 1'b1, 1'b0);
    send_item(esc_pkg::MODE_DECODE, 8'h20, 1'b0, 1'b1);
    // Encode item in the middle clears the pending escape
    send_item(esc_pkg::MODE_DECODE, esc_pkg::ESC_CHAR, 1'b1, 1'b0);
    send_item(esc_pkg::MODE_ENCODE, 8'h61, 1'b1, 1'b1);
    send_item(esc_pkg::MODE_DECODE, esc_pkg::CODE_LF, 1'b0, 1'b1);
    // New first byte abandons a pending escape
    send_item(esc_pkg::MODE_DECODE, esc_pkg::ESC_CHAR, 1'b1, 1'b0);
    send_item(esc_pkg::MODE_DECODE, esc_pkg::CHAR_LF, 1'b1, 1'b1);
  endtask

  // Delimiter extremes, and a stop byte equal to the escape character
  task automatic test_delimiters();
    logic [7:0] starts[3];
    logic [7:0] stops[3];
    starts = '{8'h00, 8'hFF, 8'h7E};
    stops  = '{8'hFF, 8'h00, esc_pkg::ESC_CHAR};
    for (int i = 0; i < 3; i++) begin
      set_delimiters(starts[i], stops[i]);
      send_item(esc_pkg::MODE_ENCODE, 8'h00, 1'b1, 1'b0);
      send_item(esc_pkg::MODE_ENCODE, 8'hFF, 1'b0, 1'b1);
      send_item(esc_pkg::MODE_DECODE, 8'h41, 1'b1, 1'b0);
      send_item(esc_pkg::MODE_DECODE, cfg_stop, 1'b0, 1'b0);
    end
  endtask

  // One random message: encode, well-formed decode, or noise
  task automatic send_random_message();
    logic [7:0] frame[$];
    int roll;
    int len;
    int ending;
    logic last_on_stop;
    logic noise_mode;
    roll = $urandom_range(99);
    if (roll < 35) begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++)
        send_item(esc_pkg::MODE_ENCODE, pick_byte(), i == 0, i == len - 1);
    end else if (roll < 80) begin
      // Build an escaped frame, mostly valid
      len = $urandom_range(1, 5);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(99) < 35) begin
          frame.insert(frame.size(), esc_pkg::ESC_CHAR);
          if ($urandom_range(99) < 6) frame.insert(frame.size(), 8'($urandom_range(255)));
          else frame.insert(frame.size(), 8'($urandom_range(1, 3)));
        end else begin
          frame.insert(frame.size(), plain_byte());
        end
      end
      ending = $urandom_range(99);
      last_on_stop = $urandom_range(1);
      if (ending < 45) begin
        for (int i = 0; i < frame.size(); i++)
          send_item(esc_pkg::MODE_DECODE, frame[i], i == 0, i == frame.size() - 1);
      end else begin
        if (ending < 90) frame.insert(frame.size(), cfg_stop);
        else frame.insert(frame.size(), esc_pkg::ESC_CHAR);
        for (int i = 0; i < frame.size(); i++)
          send_item(esc_pkg::MODE_DECODE, frame[i], i == 0,
                    (i == frame.size() - 1) && (last_on_stop || ending >= 90));
      end
    end else begin
      len = $urandom_range(1, 4);
      for (int i = 0; i < len; i++) begin
        noise_mode = ($urandom_range(99) < 15) ? esc_pkg::MODE_ENCODE : esc_pkg::MODE_DECODE;
        send_item(noise_mode, pick_byte(),
                  $urandom_range(99) < 25, $urandom_range(99) < 25);
      end
    end
  endtask

  // Random traffic under each idling pattern, new delimiters per phase
  task automatic test_random_traffic();
    int send_pcts[4];
    int stall_pcts[4];
    int goal;
    send_pcts  = '{0, 66, 0, 27};
    stall_pcts = '{0, 0, 66, 27};
    for (int p = 0; p < 4; p++) begin
      if (p == 0) set_delimiters(esc_pkg::START_RESET, esc_pkg::STOP_RESET);
      else set_delimiters(8'($urandom_range(255)), 8'($urandom_range(255)));
      send_idle_pct  = send_pcts[p];
      recv_stall_pct = stall_pcts[p];
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) send_random_message();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_encode_directed();
    test_decode_directed();
    test_delimiters();
    test_random_traffic();
    wait_idle();
    $display("Sent %0d items in encode and decode mode, checked %0d result items,",
             items_sent, results_checked);
    $display("across default and extreme delimiters and four idling patterns.");
    if (error_count == 0) begin
      $display("** escape_byte_stuffing_codec_unit: PASSED **");
    end else begin
      $display("** escape_byte_stuffing_codec_unit: FAILED **");
    end
    $finish;
  end

  // Hold a hard limit on the run
  initial begin
    #2000000;
    $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
    $display("** escape_byte_stuffing_codec_unit: FAILED **");
    $finish;
  end

endmodule
